/* design/sph_gradient_correction_matrix_defines.svh */
// ---------------------------------------------------------------------------
// sph_gradient_correction_matrix_defines.svh
// Assertion macros used by the gradient correction matrix sequencer (sph_gcm_ctrl).
// ---------------------------------------------------------------------------
`ifndef SPH_GRADIENT_CORRECTION_MATRIX_DEFINES_SVH
`define SPH_GRADIENT_CORRECTION_MATRIX_DEFINES_SVH

// same-cycle implication
`define SPH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/sph_gcm_pkg.sv */
// ---------------------------------------------------------------------------
// sph_gcm_pkg
// Types, widths and command/status structures of the gradient correction
// matrix block.
// ---------------------------------------------------------------------------
package sph_gcm_pkg;

   localparam int MAX_PARTICLES = 4096;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int FRAC_BITS     = 16;
   localparam int VAL_W         = 32;
   localparam int MASS_W        = 31;
   localparam int ACC_W         = 48;
   localparam int KIND_W        = 3;
   localparam int REQ_W         = 2;
   localparam int PROD_W        = 2 * VAL_W;
   localparam int WSUM_W        = 2 * ACC_W;
   localparam int DET_W         = 2 * ACC_W + 1;
   localparam int DIV_NUM_W     = ACC_W + 2 * FRAC_BITS;
   localparam int DIV_DEN_W     = 2 * ACC_W;
   localparam int DIV_CNT_W     = $clog2(DIV_NUM_W + 1);

   localparam logic [KIND_W-1:0] KIND_NORMAL   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NULL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BOUNDARY = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DUMMY    = 3'd3;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD, REQ_PAIR, REQ_INVERT, REQ_NONE
   } req_code_type;

   typedef enum logic [1:0] {
      ADDR_I, ADDR_J, ADDR_CLR
   } addr_sel_type;

   typedef enum logic [1:0] {
      MS_PK, MS_TLO, MS_THI, MS_DET
   } mul_src_type;

   typedef enum logic {
      DS_VOL, DS_INV
   } div_src_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_LD_WAIT, ST_LD_WRITE,
      ST_PK, ST_PK_DRAIN, ST_ACC_RD, ST_TLO, ST_THI, ST_TADD, ST_TFIN,
      ST_ACC_WR, ST_INV_RD, ST_DP_ISSUE, ST_DP_DRAIN, ST_DP_ADD,
      ST_INV_CHK, ST_DIV_WAIT, ST_EMIT
   } state_type;

   typedef logic [3:0][ACC_W-1:0] acc_row_type;

   typedef struct packed {
      logic         cap;
      logic         vol_rd_i;
      logic         vol_rd_j;
      logic         vol_wr;
      logic         acc_rd;
      addr_sel_type acc_rd_sel;
      logic         acc_wr;
      logic         acc_wr_zero;
      addr_sel_type acc_wr_sel;
      logic         clr_inc;
      logic         mul_go;
      mul_src_type  mul_src;
      logic [1:0]   k;
      logic         pr;
      logic         side;
      logic         wsum_clr;
      logic         term_lat;
      logic         det_clr;
      logic         det_add;
      logic         div_go;
      div_src_type  div_src;
      logic [1:0]   div_k;
      logic         inv_lat;
      logic         out_sing;
   } cmd_type;

   typedef struct packed {
      req_code_type req;
      logic         pair_ok;
      logic         upd_j;
      logic         div_done;
      logic         det_zero;
      logic         clr_last;
   } status_type;

endpackage

/* design/sph_gradient_correction_matrix.sv */
// ---------------------------------------------------------------------------
// sph_gradient_correction_matrix
// 2D corrective gradient matrix per particle, Q16.16 fixed point.
//
// Requests enter on the req_ ports: a transfer happens when start is high
// and busy is low. req_type selects load (store volume and fluid flag, clear
// the accumulators), pair (accumulate into particle i and, when updated, j) or invert.
// Only invert produces a result: rsp_valid is high for exactly one cycle
// with the inverse matrix on the rsp_ ports; the receiver cannot stall.
// csr_we/csr_wdata write extended_mode; the user must write only while busy is low (unchecked).
// Busy stays high until a request is done; the next transfer can follow
// in the first cycle with busy low. Per request:
//   load   one 80-step restoring division, one bit per cycle
//   pair   particle i, and particle j too when it is updated
//          (one shared 32x32 multiplier, one accumulator row per side)
//   invert determinant on the shared multiplier, then four divisions;
//          only the determinant when the matrix is singular;
//          the result strobe is in the last busy cycle.
// After reset busy stays high while the accumulator memory is cleared,
// all 4096 rows, one row per cycle.
// ---------------------------------------------------------------------------
module sph_gradient_correction_matrix
   import sph_gcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [IDX_W-1:0]  req_index_i,
   input  logic [IDX_W-1:0]  req_index_j,
   input  logic [MASS_W-1:0] req_mass,
   input  logic [MASS_W-1:0] req_density,
   input  logic              req_is_fluid,
   input  logic [KIND_W-1:0] req_pair_kind,
   input  logic [VAL_W-1:0]  req_dx,
   input  logic [VAL_W-1:0]  req_dy,
   input  logic [VAL_W-1:0]  req_grad_x,
   input  logic [VAL_W-1:0]  req_grad_y,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_particle,
   output logic [VAL_W-1:0]  rsp_inv_xx,
   output logic [VAL_W-1:0]  rsp_inv_yx,
   output logic [VAL_W-1:0]  rsp_inv_xy,
   output logic [VAL_W-1:0]  rsp_inv_yy,
   output logic              rsp_singular,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   cmd_type    cmd;
   status_type status;

   sph_gcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   sph_gcm_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_type      (req_type),
      .req_index_i   (req_index_i),
      .req_index_j   (req_index_j),
      .req_mass      (req_mass),
      .req_density   (req_density),
      .req_is_fluid  (req_is_fluid),
      .req_pair_kind (req_pair_kind),
      .req_dx        (req_dx),
      .req_dy        (req_dy),
      .req_grad_x    (req_grad_x),
      .req_grad_y    (req_grad_y),
      .rsp_particle  (rsp_particle),
      .rsp_inv_xx    (rsp_inv_xx),
      .rsp_inv_yx    (rsp_inv_yx),
      .rsp_inv_xy    (rsp_inv_xy),
      .rsp_inv_yy    (rsp_inv_yy),
      .rsp_singular  (rsp_singular)
   );

endmodule

/* design/sph_gcm_div.sv */
// ---------------------------------------------------------------------------
// sph_gcm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sph_gcm_div
   import sph_gcm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   logic                 run_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff, den_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W:0]   shifted, diff;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};
   assign rem_in  = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start) begin
            run_ff  <= 1'b1;
            done_ff <= 1'b0;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
         end else if (run_ff) begin
            cnt_ff  <= cnt_ff - 1'b1;
            run_ff  <= (cnt_ff != DIV_CNT_W'(1));
            done_ff <= (cnt_ff == DIV_CNT_W'(1));
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* design/sph_gcm_dp.sv */
// ---------------------------------------------------------------------------
// sph_gcm_dp
// Datapath: request registers, volume and accumulator memories, shared
// 32x32 multiplier with wide accumulator, determinant and divider.
// ---------------------------------------------------------------------------
module sph_gcm_dp
   import sph_gcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_we,
   input  logic               csr_wdata,
   input  logic [REQ_W-1:0]   req_type,
   input  logic [IDX_W-1:0]   req_index_i,
   input  logic [IDX_W-1:0]   req_index_j,
   input  logic [MASS_W-1:0]  req_mass,
   input  logic [MASS_W-1:0]  req_density,
   input  logic               req_is_fluid,
   input  logic [KIND_W-1:0]  req_pair_kind,
   input  logic [VAL_W-1:0]   req_dx,
   input  logic [VAL_W-1:0]   req_dy,
   input  logic [VAL_W-1:0]   req_grad_x,
   input  logic [VAL_W-1:0]   req_grad_y,
   output logic [IDX_W-1:0]   rsp_particle,
   output logic [VAL_W-1:0]   rsp_inv_xx,
   output logic [VAL_W-1:0]   rsp_inv_yx,
   output logic [VAL_W-1:0]   rsp_inv_xy,
   output logic [VAL_W-1:0]   rsp_inv_yy,
   output logic               rsp_singular
);

   localparam logic [WSUM_W-1:0] ACC_POS_LIM = WSUM_W'((64'd1 << (ACC_W - 1)) - 64'd1);
   localparam logic [WSUM_W-1:0] ACC_NEG_LIM = WSUM_W'(64'd1 << (ACC_W - 1));
   localparam logic [DIV_NUM_W-1:0] OUT_POS_LIM = DIV_NUM_W'((64'd1 << (VAL_W - 1)) - 64'd1);
   localparam logic [DIV_NUM_W-1:0] OUT_NEG_LIM = DIV_NUM_W'(64'd1 << (VAL_W - 1));

   typedef struct packed {
      logic        go;
      mul_src_type src;
      logic [1:0]  k;
   } tag_type;

   function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
      return v[VAL_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [ACC_W-1:0] mag48(input logic [ACC_W-1:0] v);
      return v[ACC_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [ACC_W-1:0] sat_acc(input logic [WSUM_W-1:0] m, input logic neg);
      logic [ACC_W-1:0] r;
      if (neg) begin
         r = (m > ACC_NEG_LIM) ? ACC_NEG_LIM[ACC_W-1:0] : (~m[ACC_W-1:0] + 1'b1);
      end else begin
         r = (m > ACC_POS_LIM) ? ACC_POS_LIM[ACC_W-1:0] : m[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] sat_out(input logic [DIV_NUM_W-1:0] q, input logic neg);
      logic [VAL_W-1:0] r;
      if (neg) begin
         r = (q > OUT_NEG_LIM) ? OUT_NEG_LIM[VAL_W-1:0] : (~q[VAL_W-1:0] + 1'b1);
      end else begin
         r = (q > OUT_POS_LIM) ? OUT_POS_LIM[VAL_W-1:0] : q[VAL_W-1:0];
      end
      return r;
   endfunction

   // output element k draws on accumulator entry: xx<-yy, yx<-yx, xy<-xy, yy<-xx
   function automatic logic [1:0] elem_map(input logic [1:0] k);
      return {~(k[0] ^ k[1]) ^ k[1], ~(k[0] ^ k[1]) ^ k[0]};
   endfunction

   // request registers
   req_code_type       req_ff;
   logic [IDX_W-1:0]   idx_i_ff, idx_j_ff;
   logic [MASS_W-1:0]  mass_ff, dens_ff;
   logic               fluid_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [VAL_W-1:0]   dx_ff, dy_ff, gx_ff, gy_ff;
   logic               ext_ff;

   // memories
   logic [VAL_W:0]     vol_mem [MAX_PARTICLES];
   acc_row_type        acc_mem [MAX_PARTICLES];
   logic [VAL_W:0]     vol_q_ff, voli_ff, volj_ff;
   logic               lat_i_ff, lat_j_ff;
   acc_row_type        acc_rd_ff, acc_wdata;
   logic [IDX_W-1:0]   clr_ff, rd_addr, wr_addr, vol_addr;

   // arithmetic
   logic [PROD_W-1:0]  pk_ff [4];
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [VAL_W-1:0]   mul_a, mul_b;
   tag_type            tag_ff;
   logic [WSUM_W-1:0]  wsum_ff, wsum_add;
   logic [ACC_W-1:0]   term_ff [4];
   logic signed [DET_W-1:0] det_ff;
   logic [DET_W-1:0]   det_neg, det_abs, det_delta;
   logic               det_sub;
   logic [VAL_W-1:0]   off_k, grad_k, vol_s;
   logic [ACC_W-1:0]   dx_a, dy_a, det_x, det_y;
   logic [ACC_W-1:0]   inv_e;
   logic [1:0]         emap;
   logic               inv_neg_ff;
   logic [VAL_W-1:0]   out_ff [4];
   logic               sing_ff;

   // divider
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [VAL_W-1:0]     vol_sat;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         req_ff   <= req_code_type'(req_type);
         idx_i_ff <= req_index_i;
         idx_j_ff <= req_index_j;
         mass_ff  <= req_mass;
         dens_ff  <= req_density;
         fluid_ff <= req_is_fluid;
         kind_ff  <= req_pair_kind;
         dx_ff    <= req_dx;
         dy_ff    <= req_dy;
         gx_ff    <= req_grad_x;
         gy_ff    <= req_grad_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff   <= 1'b0;
         clr_ff   <= '0;
         lat_i_ff <= 1'b0;
         lat_j_ff <= 1'b0;
         tag_ff   <= '0;
      end else begin
         if (csr_we) begin
            ext_ff <= csr_wdata;
         end
         if (cmd.clr_inc) begin
            clr_ff <= clr_ff + 1'b1;
         end
         lat_i_ff <= cmd.vol_rd_i;
         lat_j_ff <= cmd.vol_rd_j;
         tag_ff   <= '{go: cmd.mul_go, src: cmd.mul_src, k: cmd.k};
      end
   end

   function automatic logic [IDX_W-1:0] pick_addr(input addr_sel_type sel,
                                                  input logic [IDX_W-1:0] ai,
                                                  input logic [IDX_W-1:0] aj,
                                                  input logic [IDX_W-1:0] ac);
      logic [IDX_W-1:0] r;
      unique case (sel)
         ADDR_I:   r = ai;
         ADDR_J:   r = aj;
         ADDR_CLR: r = ac;
         default:  r = ai;
      endcase
      return r;
   endfunction

   assign rd_addr  = pick_addr(cmd.acc_rd_sel, idx_i_ff, idx_j_ff, clr_ff);
   assign wr_addr  = pick_addr(cmd.acc_wr_sel, idx_i_ff, idx_j_ff, clr_ff);
   assign vol_addr = cmd.vol_rd_j ? idx_j_ff : idx_i_ff;
   assign vol_sat  = (|div_quo[DIV_NUM_W-1:VAL_W]) ? '1 : div_quo[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.vol_wr) begin
         vol_mem[idx_i_ff] <= {fluid_ff, vol_sat};
      end
      if (cmd.vol_rd_i || cmd.vol_rd_j) begin
         vol_q_ff <= vol_mem[vol_addr];
      end
      if (lat_i_ff) begin
         voli_ff <= vol_q_ff;
      end
      if (lat_j_ff) begin
         volj_ff <= vol_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_wr) begin
         acc_mem[wr_addr] <= acc_wdata;
      end
      if (cmd.acc_rd) begin
         acc_rd_ff <= acc_mem[rd_addr];
      end
   end

   always_comb begin
      logic [ACC_W:0] s;
      acc_wdata = '0;
      for (int e = 0; e < 4; e++) begin
         s = {acc_rd_ff[e][ACC_W-1], acc_rd_ff[e]} + {term_ff[e][ACC_W-1], term_ff[e]};
         if (s[ACC_W] != s[ACC_W-1]) begin
            acc_wdata[e] = s[ACC_W] ? ACC_NEG_LIM[ACC_W-1:0] : ACC_POS_LIM[ACC_W-1:0];
         end else begin
            acc_wdata[e] = s[ACC_W-1:0];
         end
      end
      if (cmd.acc_wr_zero) begin
         acc_wdata = '0;
      end
   end

   // multiplier operands
   assign off_k  = cmd.k[0] ? dy_ff : dx_ff;
   assign grad_k = cmd.k[1] ? gy_ff : gx_ff;
   assign vol_s  = cmd.side ? voli_ff[VAL_W-1:0] : volj_ff[VAL_W-1:0];
   assign det_x  = cmd.pr ? acc_rd_ff[1] : acc_rd_ff[0];
   assign det_y  = cmd.pr ? acc_rd_ff[2] : acc_rd_ff[3];
   assign dx_a   = mag48(det_x);
   assign dy_a   = mag48(det_y);

   always_comb begin
      case (cmd.mul_src)
         MS_PK: begin
            mul_a = mag32(off_k);
            mul_b = mag32(grad_k);
         end
         MS_TLO: begin
            mul_a = pk_ff[cmd.k][VAL_W-1:0];
            mul_b = vol_s;
         end
         MS_THI: begin
            mul_a = pk_ff[cmd.k][PROD_W-1:VAL_W];
            mul_b = vol_s;
         end
         default: begin
            mul_a = cmd.k[0] ? VAL_W'(dx_a[ACC_W-1:VAL_W]) : dx_a[VAL_W-1:0];
            mul_b = cmd.k[1] ? VAL_W'(dy_a[ACC_W-1:VAL_W]) : dy_a[VAL_W-1:0];
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (tag_ff.src)
         MS_THI:  wsum_add = WSUM_W'(prod_ff) << VAL_W;
         MS_DET: begin
            if (tag_ff.k == 2'd0) begin
               wsum_add = WSUM_W'(prod_ff);
            end else if (tag_ff.k == 2'd3) begin
               wsum_add = WSUM_W'(prod_ff) << (2 * VAL_W);
            end else begin
               wsum_add = WSUM_W'(prod_ff) << VAL_W;
            end
         end
         default: wsum_add = WSUM_W'(prod_ff);
      endcase
   end

   // determinant: det = xx*yy - yx*xy
   assign det_sub   = cmd.pr ? ~(det_x[ACC_W-1] ^ det_y[ACC_W-1])
                             : (det_x[ACC_W-1] ^ det_y[ACC_W-1]);
   assign det_delta = det_sub ? (~{1'b0, wsum_ff} + 1'b1) : {1'b0, wsum_ff};
   assign det_neg   = ~det_ff + 1'b1;
   assign det_abs   = det_ff[DET_W-1] ? det_neg : det_ff;

   assign emap  = elem_map(cmd.div_k);
   assign inv_e = acc_rd_ff[emap];

   always_comb begin
      if (cmd.div_src == DS_INV) begin
         div_num = {mag48(inv_e), {(2 * FRAC_BITS){1'b0}}};
         div_den = det_abs[DIV_DEN_W-1:0];
      end else begin
         div_num = DIV_NUM_W'({mass_ff, {FRAC_BITS{1'b0}}});
         div_den = DIV_DEN_W'(dens_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.wsum_clr) begin
         wsum_ff <= '0;
      end else if (tag_ff.go && tag_ff.src != MS_PK) begin
         wsum_ff <= wsum_ff + wsum_add;
      end
      if (tag_ff.go && tag_ff.src == MS_PK) begin
         pk_ff[tag_ff.k] <= prod_ff;
      end
      if (cmd.term_lat) begin
         term_ff[cmd.k] <= sat_acc(wsum_ff >> (2 * FRAC_BITS),
                                   off_k[VAL_W-1] ^ grad_k[VAL_W-1]);
      end
      if (cmd.det_clr) begin
         det_ff <= '0;
      end else if (cmd.det_add) begin
         det_ff <= det_ff + $signed(det_delta);
      end
      if (cmd.div_go) begin
         inv_neg_ff <= inv_e[ACC_W-1] ^ det_ff[DET_W-1] ^ (cmd.div_k[0] ^ cmd.div_k[1]);
      end
      if (cmd.out_sing) begin
         for (int e = 0; e < 4; e++) begin
            out_ff[e] <= '0;
         end
         sing_ff <= 1'b1;
      end else if (cmd.inv_lat) begin
         out_ff[cmd.k] <= sat_out(div_quo, inv_neg_ff);
         sing_ff       <= 1'b0;
      end
   end

   sph_gcm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign status.req      = req_ff;
   assign status.pair_ok  = (kind_ff == KIND_NORMAL) || (kind_ff == KIND_NULL) ||
                            (ext_ff && ((kind_ff == KIND_BOUNDARY) || (kind_ff == KIND_DUMMY)));
   assign status.upd_j    = (idx_j_ff != idx_i_ff) && (!ext_ff || volj_ff[VAL_W]);
   assign status.div_done = div_done;
   assign status.det_zero = (det_ff == '0);
   assign status.clr_last = (clr_ff == IDX_W'(MAX_PARTICLES - 1));

   assign rsp_particle = idx_i_ff;
   assign rsp_inv_xx   = out_ff[0];
   assign rsp_inv_yx   = out_ff[1];
   assign rsp_inv_xy   = out_ff[2];
   assign rsp_inv_yy   = out_ff[3];
   assign rsp_singular = sing_ff;

endmodule

/* design/sph_gcm_ctrl.sv */
// ---------------------------------------------------------------------------
// sph_gcm_ctrl
// Sequencer for load, pair and invert requests and the post-reset clear.
// ---------------------------------------------------------------------------
`include "sph_gradient_correction_matrix_defines.svh"

module sph_gcm_ctrl
   import sph_gcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic       pr_ff, pr_in;
   logic       side_ff, side_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= '0;
         pr_ff    <= 1'b0;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         pr_ff    <= pr_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      pr_in    = pr_ff;
      side_in  = side_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            k_in    = '0;
            pr_in   = 1'b0;
            side_in = 1'b0;
            case (status.req)
               REQ_LOAD:   state_in = ST_LD_WAIT;
               REQ_PAIR:   state_in = status.pair_ok ? ST_PK : ST_IDLE;
               REQ_INVERT: state_in = ST_INV_RD;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_LD_WAIT: begin
            if (status.div_done) begin
               state_in = ST_LD_WRITE;
            end
         end
         ST_LD_WRITE: state_in = ST_IDLE;
         ST_PK: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_PK_DRAIN;
            end
         end
         ST_PK_DRAIN: state_in = ST_ACC_RD;
         ST_ACC_RD: begin
            k_in     = '0;
            state_in = ST_TLO;
         end
         ST_TLO:  state_in = ST_THI;
         ST_THI:  state_in = ST_TADD;
         ST_TADD: state_in = ST_TFIN;
         ST_TFIN: begin
            k_in     = k_ff + 1'b1;
            state_in = (k_ff == 2'd3) ? ST_ACC_WR : ST_TLO;
         end
         ST_ACC_WR: begin
            if (!side_ff && status.upd_j) begin
               side_in  = 1'b1;
               state_in = ST_ACC_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_INV_RD: begin
            k_in     = '0;
            pr_in    = 1'b0;
            state_in = ST_DP_ISSUE;
         end
         ST_DP_ISSUE: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_DP_DRAIN;
            end
         end
         ST_DP_DRAIN: state_in = ST_DP_ADD;
         ST_DP_ADD: begin
            k_in = '0;
            if (!pr_ff) begin
               pr_in    = 1'b1;
               state_in = ST_DP_ISSUE;
            end else begin
               state_in = ST_INV_CHK;
            end
         end
         ST_INV_CHK: begin
            k_in     = '0;
            state_in = status.det_zero ? ST_EMIT : ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               k_in = k_ff + 1'b1;
               if (k_ff == 2'd3) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.k       = k_ff;
      cmd.pr      = pr_ff;
      cmd.side    = side_ff;
      cmd.div_k   = k_ff;
      cmd.mul_src = MS_PK;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.acc_wr      = 1'b1;
            cmd.acc_wr_zero = 1'b1;
            cmd.acc_wr_sel  = ADDR_CLR;
            cmd.clr_inc     = 1'b1;
         end
         ST_IDLE: begin
            cmd.cap = start;
         end
         ST_DECODE: begin
            if (status.req == REQ_LOAD) begin
               cmd.div_go      = 1'b1;
               cmd.div_src     = DS_VOL;
               cmd.acc_wr      = 1'b1;
               cmd.acc_wr_zero = 1'b1;
               cmd.acc_wr_sel  = ADDR_I;
            end
            if (status.req == REQ_INVERT) begin
               cmd.acc_rd     = 1'b1;
               cmd.acc_rd_sel = ADDR_I;
               cmd.det_clr    = 1'b1;
            end
         end
         ST_LD_WRITE: begin
            cmd.vol_wr = 1'b1;
         end
         ST_PK: begin
            cmd.mul_go   = 1'b1;
            cmd.mul_src  = MS_PK;
            cmd.vol_rd_j = (k_ff == 2'd0);
            cmd.vol_rd_i = (k_ff == 2'd1);
         end
         ST_ACC_RD: begin
            cmd.acc_rd     = 1'b1;
            cmd.acc_rd_sel = side_ff ? ADDR_J : ADDR_I;
         end
         ST_TLO: begin
            cmd.wsum_clr = 1'b1;
            cmd.mul_go   = 1'b1;
            cmd.mul_src  = MS_TLO;
         end
         ST_THI: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_src = MS_THI;
         end
         ST_TFIN: begin
            cmd.term_lat = 1'b1;
         end
         ST_ACC_WR: begin
            cmd.acc_wr     = 1'b1;
            cmd.acc_wr_sel = side_ff ? ADDR_J : ADDR_I;
         end
         ST_DP_ISSUE: begin
            cmd.wsum_clr = (k_ff == 2'd0);
            cmd.mul_go   = 1'b1;
            cmd.mul_src  = MS_DET;
         end
         ST_DP_ADD: begin
            cmd.det_add = 1'b1;
         end
         ST_INV_CHK: begin
            cmd.div_k   = '0;
            cmd.div_src = DS_INV;
            if (status.det_zero) begin
               cmd.out_sing = 1'b1;
            end else begin
               cmd.div_go = 1'b1;
            end
         end
         ST_DIV_WAIT: begin
            cmd.div_src = DS_INV;
            cmd.div_k   = k_ff + 1'b1;
            if (status.div_done) begin
               cmd.inv_lat = 1'b1;
               cmd.div_go  = (k_ff != 2'd3);
            end
         end
         default: begin
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   `SPH_ASSERT_NEXT(a_emit_single, clock, reset, state_ff == ST_EMIT, state_ff == ST_IDLE, "result strobe held past one cycle")
   `SPH_ASSERT_NEXT(a_accept_decode, clock, reset, start && !busy, state_ff == ST_DECODE, "accepted request not decoded")
   `SPH_ASSERT_NEXT(a_div_no_early_done, clock, reset, cmd.div_go, !status.div_done, "divider finished right after start")

endmodule
